>>> hdl/fslf_pkg.sv
// Shared constants, types and helpers for the fixed-string line filter.
`timescale 1ns / 1ps
package fslf_pkg;

   localparam int PATTERN_MAX     = 16;
   localparam int LINE_COUNT_BITS = 32;
   localparam int REG_PAT_BYTES   = 16;
   localparam int LEN_BITS        = 5;
   localparam int LINE_NUM_BITS   = 32;
   localparam int CSR_ADDR_BITS   = 6;
   localparam int CSR_DATA_BITS   = 64;
   localparam int CSR_INDEX_LSB   = 3;

   typedef enum logic [2:0] {
      CSR_PATTERN_LOW  = 3'd0,
      CSR_PATTERN_HIGH = 3'd1,
      CSR_PATTERN_LEN  = 3'd2,
      CSR_IGNORE_CASE  = 3'd3,
      CSR_INVERT_MATCH = 3'd4
   } csr_index_type;

   typedef struct packed {
      logic [63:0]         pattern_bytes_low;
      logic [63:0]         pattern_bytes_high;
      logic [LEN_BITS-1:0] pattern_length;
      logic                ignore_case;
      logic                invert_match;
   } cfg_type;

   typedef struct packed {
      logic active;
      logic match;
   } link_type;

   function automatic logic [7:0] fold_byte(input logic [7:0] c, input logic ignore_case);
      if (ignore_case && c >= 8'h41 && c <= 8'h5A) begin
         return c + 8'h20;
      end
      return c;
   endfunction

endpackage

>>> hdl/fslf_csr.sv
// Configuration register file behind the APB-style port.
`timescale 1ns / 1ps
module fslf_csr (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                psel,
   input  logic                                penable,
   input  logic                                pwrite,
   input  logic [fslf_pkg::CSR_ADDR_BITS-1:0]  paddr,
   input  logic [fslf_pkg::CSR_DATA_BITS-1:0]  pwdata,
   output logic [fslf_pkg::CSR_DATA_BITS-1:0]  prdata,
   output logic                                pready,
   output fslf_pkg::cfg_type                   cfg
);
   import fslf_pkg::*;

   cfg_type       cfg_ff;
   cfg_type       cfg_in;
   csr_index_type index;
   logic          write_en;

   assign pready   = 1'b1;
   assign index    = csr_index_type'(paddr[CSR_ADDR_BITS-1:CSR_INDEX_LSB]);
   assign write_en = psel && penable && pwrite && pready;
   assign cfg      = cfg_ff;

   always_comb begin
      cfg_in = cfg_ff;
      if (write_en) begin
         unique case (index)
            CSR_PATTERN_LOW:  cfg_in.pattern_bytes_low  = pwdata;
            CSR_PATTERN_HIGH: cfg_in.pattern_bytes_high = pwdata;
            CSR_PATTERN_LEN:  cfg_in.pattern_length     = pwdata[LEN_BITS-1:0];
            CSR_IGNORE_CASE:  cfg_in.ignore_case        = pwdata[0];
            CSR_INVERT_MATCH: cfg_in.invert_match       = pwdata[0];
            default: ;
         endcase
      end
   end

   always_comb begin
      unique case (index)
         CSR_PATTERN_LOW:  prdata = cfg_ff.pattern_bytes_low;
         CSR_PATTERN_HIGH: prdata = cfg_ff.pattern_bytes_high;
         CSR_PATTERN_LEN:  prdata = CSR_DATA_BITS'(cfg_ff.pattern_length);
         CSR_IGNORE_CASE:  prdata = CSR_DATA_BITS'(cfg_ff.ignore_case);
         CSR_INVERT_MATCH: prdata = CSR_DATA_BITS'(cfg_ff.invert_match);
         default:          prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= '0;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

endmodule

>>> hdl/fslf_cell.sv
// One shift-and cell: one pattern byte and one bit of the partial-match vector.
`timescale 1ns / 1ps
module fslf_cell (
   input  logic               clock,
   input  logic               reset,
   input  fslf_pkg::link_type prev,
   input  logic               next_active,
   input  logic [7:0]         pattern_byte,
   input  logic               length_bit,
   input  logic               ignore_case,
   input  logic [7:0]         text_fold,
   input  logic               step,
   input  logic               clear,
   output fslf_pkg::link_type link,
   output logic               hit
);
   import fslf_pkg::*;

   logic match_ff;
   logic match_in;
   logic active;
   logic equal;

   assign active   = prev.active && length_bit && (pattern_byte != 8'h00);
   assign equal    = fold_byte(pattern_byte, ignore_case) == text_fold;
   assign match_in = prev.match && equal && active;
   assign hit      = match_in && !next_active;

   assign link.active = active;
   assign link.match  = match_ff;

   always_ff @(posedge clock) begin
      if (reset || clear) begin
         match_ff <= 1'b0;
      end else if (step) begin
         match_ff <= match_in;
      end
   end

endmodule

>>> hdl/fixed_string_line_filter.sv
// Top level: fixed-string line filter built from a row of shift-and cells.
//
//   channel | direction | ports                                  | beat
//   req     | in        | req_text_byte, req_line_end            | one text byte or line end
//   rsp     | out       | rsp_line_number, rsp_line_selected     | one per line end
//   csr     | in/out    | psel penable pwrite paddr pwdata prdata | one register write/read
//
// One req beat per cycle if req_ready; the cell row updates in the cycle a byte is taken.
// A line end shows its result on rsp in the cycle after it is taken.
// Reset clears the cell row, the line state, the counter, rsp_valid and all CSR registers.
// A stalled rsp blocks only line-end beats; text bytes keep flowing.
`timescale 1ns / 1ps
module fixed_string_line_filter (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  req_valid,
   output logic                                  req_ready,
   input  logic [7:0]                            req_text_byte,
   input  logic                                  req_line_end,
   output logic                                  rsp_valid,
   input  logic                                  rsp_ready,
   output logic [fslf_pkg::LINE_NUM_BITS-1:0]    rsp_line_number,
   output logic                                  rsp_line_selected,
   input  logic                                  psel,
   input  logic                                  penable,
   input  logic                                  pwrite,
   input  logic [fslf_pkg::CSR_ADDR_BITS-1:0]    paddr,
   input  logic [fslf_pkg::CSR_DATA_BITS-1:0]    pwdata,
   output logic [fslf_pkg::CSR_DATA_BITS-1:0]    prdata,
   output logic                                  pready
);
   import fslf_pkg::*;

   cfg_type                       cfg;
   logic [2*64-1:0]               pattern_regs;
   logic [7:0]                    pattern_byte [PATTERN_MAX];
   logic [PATTERN_MAX-1:0]        length_bit;
   logic [PATTERN_MAX-1:0]        next_active;
   logic [PATTERN_MAX-1:0]        hit;
   link_type                      link [PATTERN_MAX+1];

   logic                          req_accept;
   logic                          line_accept;
   logic                          byte_accept;
   logic                          step;
   logic [7:0]                    text_fold;
   logic                          line_hit;

   logic                          found_ff;
   logic                          found_in;
   logic                          stopped_ff;
   logic                          stopped_in;
   logic [LINE_COUNT_BITS-1:0]    line_counter_ff;
   logic [LINE_COUNT_BITS-1:0]    line_counter_in;
   logic                          rsp_valid_ff;
   logic                          rsp_valid_in;
   logic [LINE_NUM_BITS-1:0]      rsp_line_number_ff;
   logic                          rsp_line_selected_ff;

   fslf_csr u_csr (
      .clock   (clock),
      .reset   (reset),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .pready  (pready),
      .cfg     (cfg)
   );

   assign pattern_regs = {cfg.pattern_bytes_high, cfg.pattern_bytes_low};

   assign req_ready   = !rsp_valid_ff || rsp_ready || !req_line_end;
   assign req_accept  = req_valid && req_ready;
   assign line_accept = req_accept && req_line_end;
   assign byte_accept = req_accept && !req_line_end;
   assign text_fold   = fold_byte(req_text_byte, cfg.ignore_case);
   assign step        = byte_accept && !stopped_ff && (req_text_byte != 8'h00);

   assign link[0] = '{active: 1'b1, match: 1'b1};

   for (genvar i = 0; i < PATTERN_MAX; i++) begin : g_cell
      if (i < REG_PAT_BYTES) begin : g_reg_byte
         assign pattern_byte[i] = pattern_regs[8*i +: 8];
      end else begin : g_zero_byte
         assign pattern_byte[i] = 8'h00;
      end

      if (i < PATTERN_MAX - 1) begin : g_next
         assign next_active[i] = link[i+2].active;
      end else begin : g_last
         assign next_active[i] = 1'b0;
      end

      assign length_bit[i] = int'(cfg.pattern_length) > i;

      fslf_cell u_cell (
         .clock        (clock),
         .reset        (reset),
         .prev         (link[i]),
         .next_active  (next_active[i]),
         .pattern_byte (pattern_byte[i]),
         .length_bit   (length_bit[i]),
         .ignore_case  (cfg.ignore_case),
         .text_fold    (text_fold),
         .step         (step),
         .clear        (line_accept),
         .link         (link[i+1]),
         .hit          (hit[i])
      );
   end

   assign line_hit = found_ff || !link[1].active;

   always_comb begin
      found_in        = found_ff;
      stopped_in      = stopped_ff;
      line_counter_in = line_counter_ff;
      if (line_accept) begin
         found_in   = 1'b0;
         stopped_in = 1'b0;
         if (line_counter_ff != '1) begin
            line_counter_in = line_counter_ff + 1'b1;
         end
      end else if (byte_accept && !stopped_ff) begin
         if (req_text_byte == 8'h00) begin
            stopped_in = 1'b1;
         end else if (|hit) begin
            found_in = 1'b1;
         end
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (line_accept) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         found_ff        <= 1'b0;
         stopped_ff      <= 1'b0;
         line_counter_ff <= '0;
         rsp_valid_ff    <= 1'b0;
      end else begin
         found_ff        <= found_in;
         stopped_ff      <= stopped_in;
         line_counter_ff <= line_counter_in;
         rsp_valid_ff    <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (line_accept) begin
         rsp_line_number_ff   <= LINE_NUM_BITS'(line_counter_in);
         rsp_line_selected_ff <= line_hit ^ cfg.invert_match;
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_line_number   = rsp_line_number_ff;
   assign rsp_line_selected = rsp_line_selected_ff;

`ifndef SYNTHESIS
   a_line_end_gives_rsp: assert property (@(posedge clock) disable iff (reset)
      line_accept |=> rsp_valid)
      else $error("line end did not raise rsp_valid");

   a_line_end_clears_state: assert property (@(posedge clock) disable iff (reset)
      line_accept |=> !found_ff && !stopped_ff && !link[1].match)
      else $error("line state not cleared after line end");

   a_byte_gives_no_rsp: assert property (@(posedge clock) disable iff (reset)
      byte_accept && !rsp_valid_ff |=> !rsp_valid)
      else $error("text byte produced a result");

   a_counter_monotonic: assert property (@(posedge clock) disable iff (reset)
      1'b1 |=> line_counter_ff >= $past(line_counter_ff))
      else $error("line counter went backwards");

   a_stopped_freezes_row: assert property (@(posedge clock) disable iff (reset)
      stopped_ff && !line_accept |=> $stable(found_ff))
      else $error("found flag moved after zero byte");
`endif

endmodule

>>> test/testbench.sv
// Self-checking testbench for the fixed-string line filter against a shift-and predictor.
`timescale 1ns / 1ps
module testbench;
   import fslf_pkg::*;

   typedef struct packed {
      logic [7:0] text;
      logic       line_end;
   } text_beat_type;

   typedef struct packed {
      logic [LINE_NUM_BITS-1:0] number;
      logic                     selected;
   } line_result_type;

   logic                     clock = 1'b0;
   logic                     reset = 1'b1;
   logic                     req_valid = 1'b0;
   logic                     req_ready;
   logic [7:0]               req_text_byte = 8'h00;
   logic                     req_line_end = 1'b0;
   logic                     rsp_valid;
   logic                     rsp_ready = 1'b0;
   logic [LINE_NUM_BITS-1:0] rsp_line_number;
   logic                     rsp_line_selected;
   logic                     psel = 1'b0;
   logic                     penable = 1'b0;
   logic                     pwrite = 1'b0;
   logic [CSR_ADDR_BITS-1:0] paddr = '0;
   logic [CSR_DATA_BITS-1:0] pwdata = '0;
   logic [CSR_DATA_BITS-1:0] prdata;
   logic                     pready;

   text_beat_type   beats_to_send[$];
   line_result_type expected_lines[$];
   int           failures = 0;
   int           queued_beats = 0;
   logic         req_taken = 1'b0;
   int           gap_left = 0;
   int           burst_left = 0;
   int           rx_cycle = 0;
   int           hold_left = 0;
   int           hold_served = 0;
   int           hold_requests = 0;

   logic [63:0]  pat_low = '0;
   logic [63:0]  pat_high = '0;
   logic [4:0]   pat_len = '0;
   logic         fold_case = 1'b0;
   logic         invert = 1'b0;

   logic [15:0]  match_vec = '0;
   logic         line_found = 1'b0;
   logic         line_stopped = 1'b0;
   logic [31:0]  line_count = '0;

   fixed_string_line_filter dut (.*);

   always #5 clock = ~clock;

   function automatic logic [7:0] lower_ascii(input logic [7:0] c);
      if (fold_case && c >= 8'h41 && c <= 8'h5A) begin
         return c + 8'h20;
      end
      return c;
   endfunction

   function automatic logic [7:0] pattern_byte(input int i);
      if (i < 8) begin
         return pat_low[8*i +: 8];
      end
      return pat_high[8*(i-8) +: 8];
   endfunction

   function automatic int active_length();
      int n;
      n = (pat_len > PATTERN_MAX) ? PATTERN_MAX : int'(pat_len);
      for (int i = 0; i < n; i++) begin
         if (pattern_byte(i) == 8'h00) begin
            return i;
         end
      end
      return n;
   endfunction

   task automatic track_beat(input logic [7:0] text, input logic eol);
      int              m;
      logic [15:0]     eq;
      logic [7:0]      c;
      line_result_type r;
      m = active_length();
      if (eol) begin
         if (line_count != '1) begin
            line_count = line_count + 1;
         end
         r.number = line_count;
         r.selected = (line_found || m == 0) ^ invert;
         expected_lines.push_back(r);
         match_vec = '0;
         line_found = 1'b0;
         line_stopped = 1'b0;
      end else if (!line_stopped) begin
         if (text == 8'h00) begin
            line_stopped = 1'b1;
         end else begin
            c = lower_ascii(text);
            eq = '0;
            for (int i = 0; i < m; i++) begin
               eq[i] = (lower_ascii(pattern_byte(i)) == c);
            end
            match_vec = ((match_vec << 1) | 16'h0001) & eq;
            if (m != 0 && match_vec[m-1]) begin
               line_found = 1'b1;
            end
         end
      end
   endtask

   task automatic write_reg(input csr_index_type idx, input logic [63:0] value);
      @(negedge clock);
      psel <= 1'b1;
      penable <= 1'b0;
      pwrite <= 1'b1;
      paddr <= CSR_ADDR_BITS'(idx) << CSR_INDEX_LSB;
      pwdata <= value;
      @(negedge clock);
      penable <= 1'b1;
      @(posedge clock);
      case (idx)
         CSR_PATTERN_LOW: pat_low = value;
         CSR_PATTERN_HIGH: pat_high = value;
         CSR_PATTERN_LEN: pat_len = value[4:0];
         CSR_IGNORE_CASE: fold_case = value[0];
         CSR_INVERT_MATCH: invert = value[0];
         default: ;
      endcase
      @(negedge clock);
      psel <= 1'b0;
      penable <= 1'b0;
      pwrite <= 1'b0;
   endtask

   function automatic logic [7:0] near_fold_byte();
      case ($urandom_range(0, 9))
         0: return 8'h40;
         1: return 8'h41;
         2: return 8'h5A;
         3: return 8'h5B;
         4: return 8'h60;
         5: return 8'h61;
         6: return 8'h7A;
         7: return 8'h7B;
         8: return 8'h62;
         default: return 8'h42;
      endcase
   endfunction

   function automatic logic [7:0] case_flip(input logic [7:0] c);
      if (((c >= 8'h41 && c <= 8'h5A) || (c >= 8'h61 && c <= 8'h7A)) && $urandom_range(0, 1)) begin
         return c ^ 8'h20;
      end
      return c;
   endfunction

   function automatic logic [7:0] noise_byte();
      int k;
      k = active_length();
      case ($urandom_range(0, 7))
         0: return 8'($urandom_range(1, 255));
         1, 2: begin
            if (k == 0) begin
               return near_fold_byte();
            end
            return case_flip(pattern_byte($urandom_range(0, k - 1)));
         end
         default: return near_fold_byte();
      endcase
   endfunction

   function automatic logic [63:0] random_pattern_word();
      logic [63:0] w;
      if ($urandom_range(0, 9) == 0) begin
         return '1;
      end
      for (int i = 0; i < 8; i++) begin
         if ($urandom_range(0, 31) == 0) begin
            w[8*i +: 8] = 8'h00;
         end else if ($urandom_range(0, 2) == 0) begin
            w[8*i +: 8] = 8'($urandom_range(1, 255));
         end else begin
            w[8*i +: 8] = near_fold_byte();
         end
      end
      return w;
   endfunction

   function automatic logic [4:0] pick_length();
      case ($urandom_range(0, 9))
         0: return 5'd0;
         1: return 5'd16;
         2: return 5'($urandom_range(17, 31));
         3: return 5'($urandom_range(5, 15));
         default: return 5'($urandom_range(1, 4));
      endcase
   endfunction

   task automatic queue_byte(input logic [7:0] b);
      text_beat_type t;
      t.text = b;
      t.line_end = 1'b0;
      beats_to_send.push_back(t);
      queued_beats++;
   endtask

   task automatic queue_eol();
      text_beat_type t;
      t.text = 8'($urandom);
      t.line_end = 1'b1;
      beats_to_send.push_back(t);
      queued_beats++;
   endtask

   task automatic queue_random_line(input bit close);
      int n;
      int k;
      n = active_length();
      if ($urandom_range(0, 19) == 0) begin
         repeat ($urandom_range(150, 300)) queue_byte(noise_byte());
      end
      repeat ($urandom_range(0, 4)) begin
         case ($urandom_range(0, 5))
            0, 1: repeat ($urandom_range(1, 6)) queue_byte(noise_byte());
            2, 3: for (int i = 0; i < n; i++) queue_byte(case_flip(pattern_byte(i)));
            4: begin
               k = $urandom_range(0, n);
               for (int i = 0; i < k; i++) queue_byte(case_flip(pattern_byte(i)));
            end
            default: queue_byte(($urandom_range(0, 9) == 0) ? 8'h00 : 8'($urandom));
         endcase
      end
      if (close) begin
         queue_eol();
      end
   endtask

   task automatic randomize_settings();
      logic [63:0] noise;
      noise = {$urandom, $urandom};
      if ($urandom_range(0, 1)) write_reg(CSR_PATTERN_LOW, random_pattern_word());
      if ($urandom_range(0, 2) == 0) write_reg(CSR_PATTERN_HIGH, random_pattern_word());
      if ($urandom_range(0, 1)) write_reg(CSR_PATTERN_LEN, {noise[63:5], pick_length()});
      if ($urandom_range(0, 2) == 0) write_reg(CSR_IGNORE_CASE, {noise[63:1], 1'($urandom)});
      if ($urandom_range(0, 2) == 0) write_reg(CSR_INVERT_MATCH, {noise[63:1], 1'($urandom)});
   endtask

   task automatic wait_drained();
      do begin
         @(posedge clock);
         #1;
      end while (beats_to_send.size() != 0 || req_valid || expected_lines.size() != 0);
      repeat (4) @(negedge clock);
   endtask

   always @(posedge clock) begin
      req_taken <= req_valid && req_ready;
   end

   always @(negedge clock) begin : driver
      text_beat_type b;
      if (!reset && !(req_valid && !req_taken)) begin
         if (gap_left > 0) begin
            gap_left--;
            req_valid <= 1'b0;
         end else if (beats_to_send.size() != 0) begin
            b = beats_to_send.pop_front();
            req_valid <= 1'b1;
            req_text_byte <= b.text;
            req_line_end <= b.line_end;
            if (burst_left > 1) begin
               burst_left--;
            end else begin
               burst_left = $urandom_range(1, 48);
               case ($urandom_range(0, 5))
                  0, 1: gap_left = 0;
                  2: gap_left = $urandom_range(10, 30);
                  default: gap_left = $urandom_range(1, 6);
               endcase
            end
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   always @(negedge clock) begin : receiver
      logic go;
      rx_cycle++;
      if (hold_served != hold_requests) begin
         hold_served++;
         hold_left = 400;
      end
      if (hold_left > 0) begin
         hold_left--;
         go = 1'b0;
      end else begin
         case (rx_cycle[8:7])
            0: go = 1'b1;
            1: go = 1'($urandom_range(0, 1));
            2: go = ($urandom_range(0, 3) == 0);
            default: go = ($urandom_range(0, 7) != 0);
         endcase
      end
      rsp_ready <= go;
   end

   always @(posedge clock) begin : monitor
      line_result_type want;
      if (!reset) begin
         if (rsp_valid && rsp_ready) begin
            if (expected_lines.size() == 0) begin
               $error("unexpected line result: line_number %0d, line_selected %0d",
                      rsp_line_number, rsp_line_selected);
               failures++;
            end else begin
               want = expected_lines.pop_front();
               if (rsp_line_number !== want.number) begin
                  $error("line_number: expected %0d, got %0d", want.number, rsp_line_number);
                  failures++;
               end
               if (rsp_line_selected !== want.selected) begin
                  $error("line_selected: expected %0d, got %0d", want.selected,
                         rsp_line_selected);
                  failures++;
               end
            end
         end
         if (req_valid && req_ready) begin
            track_beat(req_text_byte, req_line_end);
         end
      end
   end

   initial begin : stimulus
      bit hold_done;
      hold_done = 0;
      repeat (8) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // empty pattern after reset
      queue_eol();
      queue_byte(8'h78);
      queue_eol();
      wait_drained();

      // case folding and a zero byte in the text
      write_reg(CSR_PATTERN_LOW, 64'h0000_0000_0063_4261);
      write_reg(CSR_PATTERN_LEN, 64'd3);
      write_reg(CSR_IGNORE_CASE, 64'd1);
      queue_byte(8'h78);
      queue_byte(8'h41);
      queue_byte(8'h62);
      queue_byte(8'h43);
      queue_eol();
      queue_byte(8'h61);
      queue_byte(8'h62);
      queue_byte(8'h00);
      queue_byte(8'h63);
      queue_eol();
      wait_drained();

      // length above maximum, all-ones pattern, inverted
      write_reg(CSR_PATTERN_LOW, '1);
      write_reg(CSR_PATTERN_HIGH, '1);
      write_reg(CSR_PATTERN_LEN, 64'd31);
      write_reg(CSR_IGNORE_CASE, 64'd0);
      write_reg(CSR_INVERT_MATCH, 64'd1);
      queue_byte(8'hFF);
      queue_byte(8'hFF);
      queue_byte(8'hFF);
      queue_eol();
      wait_drained();

      // zero byte cuts the pattern short
      write_reg(CSR_PATTERN_LOW, 64'h0000_0000_FF00_5A80);
      write_reg(CSR_PATTERN_LEN, 64'd5);
      write_reg(CSR_INVERT_MATCH, 64'd0);
      queue_byte(8'h80);
      queue_byte(8'h5A);
      queue_eol();
      wait_drained();

      // change folding in the middle of a line
      queue_byte(8'h80);
      wait_drained();
      write_reg(CSR_IGNORE_CASE, 64'd1);
      queue_byte(8'h7A);
      queue_eol();
      wait_drained();

      queued_beats = 0;
      while (queued_beats < 1300) begin
         randomize_settings();
         if (!hold_done && queued_beats > 600) begin
            hold_done = 1;
            hold_requests++;
            repeat (80) begin
               if ($urandom_range(0, 4) == 0) queue_byte(noise_byte());
               else queue_eol();
            end
         end else begin
            repeat ($urandom_range(2, 10)) queue_random_line(1'b1);
            if ($urandom_range(0, 4) == 0) queue_random_line(1'b0);
         end
         wait_drained();
      end

      wait_drained();
      repeat (20) @(posedge clock);
      if (failures == 0) begin
         $display("Verification passed");
      end else begin
         $display("Verification failed");
      end
      $finish;
   end

   initial begin : watchdog
      #2000000;
      $display("Verification failed");
      $finish;
   end

endmodule
